[rtl/core/iira_pkg.sv]
// Package: sizes, operation and status codes, and control types shared by the array modules.
package iira_pkg;

    localparam int DEPTH     = 16;
    localparam int WORD_BITS = 32;
    localparam int IDX_BITS  = $clog2(DEPTH);
    localparam int CNT_BITS  = $clog2(DEPTH + 1);
    localparam int ACT_BITS  = 3;
    localparam int POS_BITS  = 4;
    localparam int ST_BITS   = 2;

    typedef enum logic [ACT_BITS-1:0] {
        ACT_INSERT      = 3'd0,
        ACT_APPEND      = 3'd1,
        ACT_REMOVE      = 3'd2,
        ACT_REMOVE_LAST = 3'd3,
        ACT_READ        = 3'd4,
        ACT_WRITE       = 3'd5
    } t_action;

    typedef enum logic [ST_BITS-1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2,
        ST_EMPTY = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        CM_HOLD,
        CM_LOAD,
        CM_INSERT,
        CM_REMOVE
    } t_cell_mode;

    typedef struct packed {
        t_cell_mode          mode;
        logic [IDX_BITS-1:0] target;
    } t_cell_ctl;

    typedef struct packed {
        t_status             status;
        logic [CNT_BITS-1:0] count;
        logic                rd_en;
        logic [IDX_BITS-1:0] rd_idx;
    } t_op_res;

endpackage

[rtl/core/iira_cell.sv]
// One storage cell of the chain: hold, load the request word, or take a neighbor's word.
module iira_cell (
    input  logic                               i_clk,
    input  logic [iira_pkg::IDX_BITS-1:0]      i_idx,
    input  iira_pkg::t_cell_ctl                i_ctl,
    input  logic                               i_en,
    input  logic [iira_pkg::WORD_BITS-1:0]     i_data,
    input  logic [iira_pkg::WORD_BITS-1:0]     i_lower,
    input  logic [iira_pkg::WORD_BITS-1:0]     i_upper,
    output logic [iira_pkg::WORD_BITS-1:0]     o_word
);
    import iira_pkg::*;

    logic [WORD_BITS-1:0] r_word;
    logic [WORD_BITS-1:0] n_word;

    always_comb begin
        n_word = r_word;
        if (i_en) begin
            unique case (i_ctl.mode)
                CM_HOLD: n_word = r_word;
                CM_LOAD: begin
                    if (i_idx == i_ctl.target) n_word = i_data;
                end
                CM_INSERT: begin
                    if (i_idx == i_ctl.target) n_word = i_data;
                    else if (i_idx > i_ctl.target) n_word = i_lower;
                end
                CM_REMOVE: begin
                    if (i_idx >= i_ctl.target) n_word = i_upper;
                end
                default: n_word = r_word;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

    assign o_word = r_word;

endmodule

[rtl/core/iira_ctrl.sv]
// Request decode: checks index, fullness and emptiness, and drives the cell chain.
module iira_ctrl (
    input  logic [iira_pkg::ACT_BITS-1:0]  i_action,
    input  logic [iira_pkg::POS_BITS-1:0]  i_position,
    input  logic [iira_pkg::CNT_BITS-1:0]  i_count,
    output iira_pkg::t_cell_ctl            o_cell_ctl,
    output iira_pkg::t_op_res              o_res
);
    import iira_pkg::*;

    logic                in_range;
    logic                full;
    logic                empty;
    logic [IDX_BITS-1:0] pos_idx;
    logic [IDX_BITS-1:0] last_idx;
    logic [CNT_BITS-1:0] cnt_inc;
    logic [CNT_BITS-1:0] cnt_dec;

    assign in_range = CNT_BITS'(i_position) < i_count;
    assign full     = i_count == CNT_BITS'(DEPTH);
    assign empty    = i_count == '0;
    assign pos_idx  = IDX_BITS'(i_position);
    assign last_idx = IDX_BITS'(i_count - CNT_BITS'(1));
    assign cnt_inc  = i_count + CNT_BITS'(1);
    assign cnt_dec  = i_count - CNT_BITS'(1);

    always_comb begin
        o_cell_ctl.mode   = CM_HOLD;
        o_cell_ctl.target = pos_idx;
        o_res.status      = ST_OK;
        o_res.count       = i_count;
        o_res.rd_en       = 1'b0;
        o_res.rd_idx      = pos_idx;
        unique case (i_action)
            ACT_INSERT: begin
                if (!(in_range || (i_position == '0 && empty))) begin
                    o_res.status = ST_RANGE;
                end else if (full) begin
                    o_res.status = ST_FULL;
                end else begin
                    o_cell_ctl.mode = CM_INSERT;
                    o_res.count     = cnt_inc;
                end
            end
            ACT_APPEND: begin
                if (full) begin
                    o_res.status = ST_FULL;
                end else begin
                    o_cell_ctl.mode   = CM_LOAD;
                    o_cell_ctl.target = IDX_BITS'(i_count);
                    o_res.count       = cnt_inc;
                end
            end
            ACT_REMOVE: begin
                if (empty) begin
                    o_res.status = ST_EMPTY;
                end else if (!in_range) begin
                    o_res.status = ST_RANGE;
                end else begin
                    o_cell_ctl.mode = CM_REMOVE;
                    o_res.rd_en     = 1'b1;
                    o_res.count     = cnt_dec;
                end
            end
            ACT_REMOVE_LAST: begin
                if (empty) begin
                    o_res.status = ST_EMPTY;
                end else begin
                    o_res.rd_en  = 1'b1;
                    o_res.rd_idx = last_idx;
                    o_res.count  = cnt_dec;
                end
            end
            ACT_READ: begin
                if (!in_range) o_res.status = ST_RANGE;
                else o_res.rd_en = 1'b1;
            end
            ACT_WRITE: begin
                if (!in_range) o_res.status = ST_RANGE;
                else o_cell_ctl.mode = CM_LOAD;
            end
            default: o_res.status = ST_OK;
        endcase
    end

endmodule

[rtl/core/indexed_insert_remove_array.sv]
// Top level: ordered word array built as a chain of shift cells, with a registered result.
//
// Input channel (i_in_valid / o_in_ready) carries one request: i_action, i_position and
// i_data_in. Output channel (o_out_valid / i_out_ready) returns one result per request:
// o_data_out (removed or read word, zero otherwise), o_status and o_count_out.
// Every request is handled at its accepting edge: the decode checks the index against the
// count, and all cells shift, load or hold together at the accepting edge. The result
// is written into the output register at that same edge.
// Throughput is one request per cycle; the next request sees the array as left by the
// previous one. A new request is taken whenever the output register is empty or is
// being taken in the same cycle, so a stalled receiver stops the input channel only
// while a result waits.
// Reset clears the count and the output valid; cell contents stay undefined until
// written and are never read before that.
module indexed_insert_remove_array (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic [iira_pkg::ACT_BITS-1:0]      i_action,
    input  logic [iira_pkg::POS_BITS-1:0]      i_position,
    input  logic [iira_pkg::WORD_BITS-1:0]     i_data_in,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic [iira_pkg::WORD_BITS-1:0]     o_data_out,
    output logic [iira_pkg::ST_BITS-1:0]       o_status,
    output logic [iira_pkg::CNT_BITS-1:0]      o_count_out
);
    import iira_pkg::*;

    logic                 r_out_valid;
    logic                 n_out_valid;
    logic [WORD_BITS-1:0] r_out_data;
    logic [WORD_BITS-1:0] n_out_data;
    logic [ST_BITS-1:0]   r_out_status;
    logic [ST_BITS-1:0]   n_out_status;
    logic [CNT_BITS-1:0]  r_out_count;
    logic [CNT_BITS-1:0]  n_out_count;
    logic [CNT_BITS-1:0]  r_count;
    logic [CNT_BITS-1:0]  n_count;

    logic                 in_acc;
    t_cell_ctl            cell_ctl;
    t_op_res              op_res;
    logic [WORD_BITS-1:0] w_word [DEPTH];

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign in_acc     = i_in_valid && o_in_ready;

    iira_ctrl u_ctrl (
        .i_action   (i_action),
        .i_position (i_position),
        .i_count    (r_count),
        .o_cell_ctl (cell_ctl),
        .o_res      (op_res)
    );

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [WORD_BITS-1:0] lower;
        logic [WORD_BITS-1:0] upper;
        if (g == 0) begin : g_first
            assign lower = i_data_in;
        end else begin : g_mid_lo
            assign lower = w_word[g-1];
        end
        if (g == DEPTH - 1) begin : g_last
            assign upper = w_word[g];
        end else begin : g_mid_hi
            assign upper = w_word[g+1];
        end
        iira_cell u_cell (
            .i_clk   (i_clk),
            .i_idx   (IDX_BITS'(g)),
            .i_ctl   (cell_ctl),
            .i_en    (in_acc),
            .i_data  (i_data_in),
            .i_lower (lower),
            .i_upper (upper),
            .o_word  (w_word[g])
        );
    end

    always_comb begin
        n_count      = r_count;
        n_out_valid  = r_out_valid;
        n_out_data   = r_out_data;
        n_out_status = r_out_status;
        n_out_count  = r_out_count;
        if (r_out_valid && i_out_ready) n_out_valid = 1'b0;
        if (in_acc) begin
            n_count      = op_res.count;
            n_out_valid  = 1'b1;
            n_out_data   = op_res.rd_en ? w_word[op_res.rd_idx] : '0;
            n_out_status = op_res.status;
            n_out_count  = op_res.count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_data   <= n_out_data;
        r_out_status <= n_out_status;
        r_out_count  <= n_out_count;
    end

    assign o_out_valid = r_out_valid;
    assign o_data_out  = r_out_data;
    assign o_status    = r_out_status;
    assign o_count_out = r_out_count;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_BITS'(DEPTH))
        else $error("element count above depth");

    a_count_reported: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_out_count == r_count))
        else $error("reported count differs from stored count");

    a_fail_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && op_res.status != ST_OK) |=> (r_count == $past(r_count)))
        else $error("failed request changed the count");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && op_res.status != ST_OK) |=> (r_out_data == '0))
        else $error("failed request returned data");

    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && cell_ctl.mode == CM_INSERT) |=>
            (r_count == $past(r_count) + CNT_BITS'(1)))
        else $error("insert did not grow the count");

endmodule

[sim/testbench.sv]
// Testbench for indexed_insert_remove_array: directed and random requests against a shadow array.
`timescale 1ns / 1ps

module testbench;
    import iira_pkg::*;

    localparam logic [ACT_BITS-1:0] ACT_SPARE_6 = 3'd6;
    localparam logic [ACT_BITS-1:0] ACT_SPARE_7 = 3'd7;
    localparam int STUCK_LIMIT = 3000;
    localparam int DRAIN_CYCLES = 4;

    typedef struct packed {
        logic [WORD_BITS-1:0] data;
        t_status              status;
        logic [CNT_BITS-1:0]  count;
    } t_array_reply;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_ready;
    logic [ACT_BITS-1:0]  i_action = '0;
    logic [POS_BITS-1:0]  i_position = '0;
    logic [WORD_BITS-1:0] i_data_in = '0;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    logic [WORD_BITS-1:0] o_data_out;
    logic [ST_BITS-1:0]   o_status;
    logic [CNT_BITS-1:0]  o_count_out;

    logic [WORD_BITS-1:0] shadow_cells [DEPTH];
    logic [CNT_BITS-1:0]  shadow_count = '0;
    t_array_reply         array_replies_due [$];
    t_array_reply         head_reply;
    int                   error_count = 0;
    int                   stuck_cycles = 0;
    int                   send_idle_pct = 0;
    int                   ready_stall_pct = 0;
    logic                 growing = 1'b1;

    indexed_insert_remove_array uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_action    (i_action),
        .i_position  (i_position),
        .i_data_in   (i_data_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_data_out  (o_data_out),
        .o_status    (o_status),
        .o_count_out (o_count_out)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic t_array_reply apply_array_op(input logic [ACT_BITS-1:0] act,
                                                    input logic [POS_BITS-1:0] pos,
                                                    input logic [WORD_BITS-1:0] din);
        t_array_reply r;
        logic         in_range;
        int           k;
        r.data = '0;
        r.status = ST_OK;
        in_range = (pos < shadow_count);
        case (act)
            ACT_INSERT: begin
                if (!(in_range || (pos == 0 && shadow_count == 0))) begin
                    r.status = ST_RANGE;
                end else if (shadow_count >= DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    for (k = shadow_count; k > pos; k--) shadow_cells[k] = shadow_cells[k-1];
                    shadow_cells[pos] = din;
                    shadow_count = shadow_count + 1'b1;
                end
            end
            ACT_APPEND: begin
                if (shadow_count >= DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    shadow_cells[shadow_count] = din;
                    shadow_count = shadow_count + 1'b1;
                end
            end
            ACT_REMOVE: begin
                if (shadow_count == 0) begin
                    r.status = ST_EMPTY;
                end else if (!in_range) begin
                    r.status = ST_RANGE;
                end else begin
                    r.data = shadow_cells[pos];
                    for (k = pos; k + 1 < shadow_count; k++) shadow_cells[k] = shadow_cells[k+1];
                    shadow_count = shadow_count - 1'b1;
                end
            end
            ACT_REMOVE_LAST: begin
                if (shadow_count == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    r.data = shadow_cells[shadow_count - 1'b1];
                    shadow_count = shadow_count - 1'b1;
                end
            end
            ACT_READ: begin
                if (!in_range) r.status = ST_RANGE;
                else r.data = shadow_cells[pos];
            end
            ACT_WRITE: begin
                if (!in_range) r.status = ST_RANGE;
                else shadow_cells[pos] = din;
            end
            default: begin
            end
        endcase
        r.count = shadow_count;
        return r;
    endfunction

    task automatic send_request(input logic [ACT_BITS-1:0] act, input logic [POS_BITS-1:0] pos,
                                input logic [WORD_BITS-1:0] din);
        if ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        i_in_valid <= 1'b1;
        i_action <= act;
        i_position <= pos;
        i_data_in <= din;
        do @(posedge i_clk); while (!(i_in_valid && o_in_ready));
        array_replies_due.push_back(apply_array_op(act, pos, din));
    endtask

    task automatic wait_for_replies;
        i_in_valid <= 1'b0;
        while (array_replies_due.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_directed;
        int n;
        send_idle_pct = 0;
        ready_stall_pct = 0;
        send_request(ACT_REMOVE_LAST, 4'd0, 32'h0);
        send_request(ACT_REMOVE, 4'd0, 32'h0);
        send_request(ACT_READ, 4'd0, 32'h0);
        send_request(ACT_WRITE, 4'd0, 32'h1234_5678);
        send_request(ACT_INSERT, 4'd5, 32'hDEAD_BEEF);
        send_request(ACT_INSERT, 4'd0, 32'h0000_0000);
        send_request(ACT_APPEND, 4'd15, 32'hFFFF_FFFF);
        send_request(ACT_INSERT, 4'd1, 32'hAAAA_AAAA);
        send_request(ACT_READ, 4'd1, 32'h0);
        send_request(ACT_READ, 4'd15, 32'h0);
        send_request(ACT_WRITE, 4'd0, 32'h5555_5555);
        send_request(ACT_SPARE_6, 4'd2, 32'hFFFF_FFFF);
        send_request(ACT_SPARE_7, 4'd15, 32'h8000_0001);
        send_request(ACT_REMOVE, 4'd1, 32'h0);
        send_request(ACT_REMOVE, 4'd9, 32'h0);
        for (n = 0; n < 14; n++) send_request(ACT_APPEND, 4'(n), $urandom);
        // array is full here
        send_request(ACT_APPEND, 4'd0, 32'h0BAD_0BAD);
        send_request(ACT_INSERT, 4'd15, 32'h0BAD_0BAD);
        send_request(ACT_READ, 4'd15, 32'h0);
        send_request(ACT_REMOVE, 4'd15, 32'h0);
        send_request(ACT_REMOVE, 4'd0, 32'h0);
        send_request(ACT_REMOVE_LAST, 4'd7, 32'h0);
    endtask

    task automatic test_random_traffic(input int n_items, input int idle_pct, input int stall_pct);
        int                   n;
        int                   roll;
        logic                 grow_op;
        logic [ACT_BITS-1:0]  act;
        logic [POS_BITS-1:0]  pos;
        logic [WORD_BITS-1:0] din;
        send_idle_pct = idle_pct;
        ready_stall_pct = stall_pct;
        n = 0;
        while (n < n_items) begin
            if (shadow_count == DEPTH) growing = 1'b0;
            else if (shadow_count == 0) growing = 1'b1;
            else if ($urandom_range(39) == 0) growing = !growing;
            roll = $urandom_range(99);
            grow_op = (roll < 40) ? growing : !growing;
            if (roll < 3) begin
                act = $urandom_range(1) ? ACT_SPARE_6 : ACT_SPARE_7;
            end else if (roll < 55) begin
                if (grow_op) act = $urandom_range(1) ? ACT_INSERT : ACT_APPEND;
                else act = $urandom_range(1) ? ACT_REMOVE : ACT_REMOVE_LAST;
            end else if (roll < 78) begin
                act = ACT_READ;
            end else begin
                act = ACT_WRITE;
            end
            if (shadow_count == 0) pos = $urandom_range(1) ? 4'd0 : 4'($urandom);
            else if ($urandom_range(9) != 0) pos = 4'($urandom_range(shadow_count - 1));
            else pos = 4'($urandom);
            case ($urandom_range(9))
                0: din = '0;
                1: din = '1;
                default: din = $urandom;
            endcase
            send_request(act, pos, din);
            if (act != ACT_SPARE_6 && act != ACT_SPARE_7) n++;
        end
    endtask

    task automatic test_sender_pause;
        test_random_traffic(40, 19, 19);
        wait_for_replies();
        test_random_traffic(40, 0, 0);
    endtask

    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= ready_stall_pct);
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (array_replies_due.size() == 0) begin
                $display("%0t: result with no request pending: data=%h status=%0d count=%0d",
                         $time, o_data_out, o_status, o_count_out);
                error_count++;
            end else begin
                head_reply = array_replies_due.pop_front();
                if (o_data_out !== head_reply.data) begin
                    $display("%0t: data_out expected %h actual %h",
                             $time, head_reply.data, o_data_out);
                    error_count++;
                end
                if (o_status !== head_reply.status) begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, head_reply.status, o_status);
                    error_count++;
                end
                if (o_count_out !== head_reply.count) begin
                    $display("%0t: count_out expected %0d actual %0d",
                             $time, head_reply.count, o_count_out);
                    error_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) stuck_cycles <= 0;
        else stuck_cycles <= stuck_cycles + 1;
        if (stuck_cycles >= STUCK_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random_traffic(330, 0, 0);
        test_random_traffic(330, 68, 0);
        test_sender_pause();
        test_random_traffic(330, 0, 68);
        test_random_traffic(330, 19, 19);
        wait_for_replies();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

[indexed_insert_remove_array.f]
rtl/core/iira_pkg.sv
rtl/core/iira_cell.sv
rtl/core/iira_ctrl.sv
rtl/core/indexed_insert_remove_array.sv
sim/testbench.sv
